@@ design/lfbx_pkg.sv @@
// ----------------------------------------------------------------------------
// Latest frame buffer exchange package
// Shared sizes, command and status codes, and the types that pass between
// the top level and the exchange core.
// ----------------------------------------------------------------------------
package lfbx_pkg;

    // Pool size and descriptor storage width.
    localparam int POOL       = 8;
    localparam int DESC_WIDTH = 32;

    // Derived widths for the free deque pointers and fill counts.
    localparam int PTR_W  = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int CNT_W  = $clog2(POOL + 1);
    localparam int HELD_W = $clog2(POOL + 3);
    localparam int SUM_W  = PTR_W + 1;

    // Fixed widths of the port fields.
    localparam int FIELD_DESC_W = 32;
    localparam int CTR_W        = 32;

    typedef logic [DESC_WIDTH-1:0]   t_desc;
    typedef logic [FIELD_DESC_W-1:0] t_field_desc;
    typedef logic [CTR_W-1:0]        t_ctr;
    typedef logic [PTR_W-1:0]        t_ptr;

    typedef enum logic [1:0] {
        CMD_QUEUE   = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_LOCK    = 2'd2,
        CMD_UNLOCK  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_AGAIN      = 3'd2,
        ST_LOCKED     = 3'd3,
        ST_NOT_LOCKED = 3'd4,
        ST_NO_ROOM    = 3'd5
    } t_status;

    // One command word as held in the input register.
    typedef struct packed {
        t_cmd        cmd;
        t_field_desc buf_desc;
        logic        repeat_req;
    } t_item;

    // One result word as presented on the output side.
    typedef struct packed {
        t_status     status;
        t_field_desc desc_out;
        logic        dropped;
        t_ctr        frames_queued;
        t_ctr        frames_dropped;
        t_ctr        frames_locked;
        t_ctr        lock_retries;
    } t_result;

    // Reduce a pointer sum that stays below twice the pool size.
    function automatic t_ptr ptr_wrap(logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(POOL)) ? (s - SUM_W'(POOL)) : s;
        return r[PTR_W-1:0];
    endfunction

endpackage

@@ design/lfbx_core.sv @@
// ----------------------------------------------------------------------------
// Latest frame buffer exchange core
// Holds the ready and busy slots, the free deque and the event counters, and
// executes one command per enabled cycle. Results are registered.
// ----------------------------------------------------------------------------
module lfbx_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lfbx_pkg::t_item  i_item,
    output lfbx_pkg::t_result o_res
);

    // Slot and deque control state.
    logic                          r_ready_valid, n_ready_valid;
    lfbx_pkg::t_desc               r_ready_desc, n_ready_desc;
    logic                          r_busy_valid, n_busy_valid;
    lfbx_pkg::t_desc               r_busy_desc, n_busy_desc;
    logic                          r_retired_valid, n_retired_valid;
    lfbx_pkg::t_ptr                r_head, n_head;
    logic [lfbx_pkg::CNT_W-1:0]    r_count, n_count;

    // Event counters.
    lfbx_pkg::t_ctr r_frames_queued, n_frames_queued;
    lfbx_pkg::t_ctr r_frames_dropped, n_frames_dropped;
    lfbx_pkg::t_ctr r_frames_locked, n_frames_locked;
    lfbx_pkg::t_ctr r_lock_retries, n_lock_retries;

    // Free deque storage and its registered read data.
    lfbx_pkg::t_desc r_deque [lfbx_pkg::POOL];
    lfbx_pkg::t_desc r_rd_q;

    // Result payload registers.
    lfbx_pkg::t_status r_status, n_status;
    lfbx_pkg::t_desc   r_desc_q, n_desc_q;
    logic              r_from_mem, n_from_mem;
    logic              r_dropped, n_dropped;

    // Deque port controls.
    logic                         wr_en;
    lfbx_pkg::t_ptr               wr_addr;
    lfbx_pkg::t_desc              wr_data;
    logic                         rd_en;
    lfbx_pkg::t_ptr               rd_addr;

    // Pointer arithmetic.
    logic [lfbx_pkg::HELD_W-1:0]  held;
    logic [lfbx_pkg::SUM_W-1:0]   ptr_sum;
    lfbx_pkg::t_ptr               head_dec;
    lfbx_pkg::t_ptr               head_inc;
    lfbx_pkg::t_ptr               tail_idx;
    lfbx_pkg::t_ptr               append_idx;
    lfbx_pkg::t_desc              in_desc;

    assign in_desc = lfbx_pkg::t_desc'(i_item.buf_desc);

    // Occupancy and deque pointer neighbors.
    always_comb begin
        held = lfbx_pkg::HELD_W'(r_count) + lfbx_pkg::HELD_W'(r_ready_valid)
             + lfbx_pkg::HELD_W'(r_busy_valid);
        ptr_sum = lfbx_pkg::SUM_W'(r_head) + lfbx_pkg::SUM_W'(r_count);
        head_dec = (r_head == '0) ? lfbx_pkg::PTR_W'(lfbx_pkg::POOL - 1)
                                  : r_head - lfbx_pkg::PTR_W'(1);
        head_inc = (r_head == lfbx_pkg::PTR_W'(lfbx_pkg::POOL - 1)) ? '0
                                  : r_head + lfbx_pkg::PTR_W'(1);
        tail_idx   = lfbx_pkg::ptr_wrap(ptr_sum - lfbx_pkg::SUM_W'(1));
        append_idx = lfbx_pkg::ptr_wrap(ptr_sum);
    end

    // Command execution.
    always_comb begin
        n_ready_valid    = r_ready_valid;
        n_ready_desc     = r_ready_desc;
        n_busy_valid     = r_busy_valid;
        n_busy_desc      = r_busy_desc;
        n_retired_valid  = r_retired_valid;
        n_head           = r_head;
        n_count          = r_count;
        n_frames_queued  = r_frames_queued;
        n_frames_dropped = r_frames_dropped;
        n_frames_locked  = r_frames_locked;
        n_lock_retries   = r_lock_retries;
        n_status         = lfbx_pkg::ST_OK;
        n_desc_q         = '0;
        n_from_mem       = 1'b0;
        n_dropped        = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = head_dec;
        wr_data          = r_ready_desc;
        rd_en            = 1'b0;
        rd_addr          = r_head;

        case (i_item.cmd)
            lfbx_pkg::CMD_QUEUE: begin
                if (held >= lfbx_pkg::HELD_W'(lfbx_pkg::POOL)) begin
                    n_status = lfbx_pkg::ST_NO_ROOM;
                end else begin
                    // A waiting ready frame goes to the front of the deque.
                    if (r_ready_valid) begin
                        wr_en            = 1'b1;
                        n_head           = head_dec;
                        n_count          = r_count + lfbx_pkg::CNT_W'(1);
                        n_frames_dropped = r_frames_dropped + lfbx_pkg::CTR_W'(1);
                        n_dropped        = 1'b1;
                    end
                    n_ready_desc    = in_desc;
                    n_ready_valid   = 1'b1;
                    n_frames_queued = r_frames_queued + lfbx_pkg::CTR_W'(1);
                end
            end
            lfbx_pkg::CMD_DEQUEUE: begin
                if (r_count == '0) begin
                    n_status = lfbx_pkg::ST_NO_FREE;
                end else begin
                    rd_en      = 1'b1;
                    n_from_mem = 1'b1;
                    n_head     = head_inc;
                    n_count    = r_count - lfbx_pkg::CNT_W'(1);
                    // Popping the last entry takes the retired buffer too.
                    if (r_count == lfbx_pkg::CNT_W'(1)) begin
                        n_retired_valid = 1'b0;
                    end
                end
            end
            lfbx_pkg::CMD_LOCK: begin
                if (r_busy_valid) begin
                    n_status = lfbx_pkg::ST_LOCKED;
                end else if (r_ready_valid) begin
                    n_busy_desc     = r_ready_desc;
                    n_busy_valid    = 1'b1;
                    n_ready_valid   = 1'b0;
                    n_desc_q        = r_ready_desc;
                    n_frames_locked = r_frames_locked + lfbx_pkg::CTR_W'(1);
                end else if (i_item.repeat_req && r_retired_valid && (r_count != '0)) begin
                    // Reuse the retired buffer at the tail of the deque.
                    rd_en           = 1'b1;
                    rd_addr         = tail_idx;
                    n_from_mem      = 1'b1;
                    n_busy_valid    = 1'b1;
                    n_count         = r_count - lfbx_pkg::CNT_W'(1);
                    n_retired_valid = 1'b0;
                    n_frames_locked = r_frames_locked + lfbx_pkg::CTR_W'(1);
                end else begin
                    n_status       = lfbx_pkg::ST_AGAIN;
                    n_lock_retries = r_lock_retries + lfbx_pkg::CTR_W'(1);
                end
            end
            lfbx_pkg::CMD_UNLOCK: begin
                if (!r_busy_valid) begin
                    n_status = lfbx_pkg::ST_NOT_LOCKED;
                end else if (r_count < lfbx_pkg::CNT_W'(lfbx_pkg::POOL)) begin
                    wr_en           = 1'b1;
                    wr_addr         = append_idx;
                    wr_data         = r_busy_desc;
                    n_count         = r_count + lfbx_pkg::CNT_W'(1);
                    n_busy_valid    = 1'b0;
                    n_retired_valid = 1'b1;
                end
            end
            default: begin
                n_status = lfbx_pkg::ST_OK;
            end
        endcase
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_valid    <= 1'b0;
            r_ready_desc     <= '0;
            r_busy_valid     <= 1'b0;
            r_busy_desc      <= '0;
            r_retired_valid  <= 1'b0;
            r_head           <= '0;
            r_count          <= '0;
            r_frames_queued  <= '0;
            r_frames_dropped <= '0;
            r_frames_locked  <= '0;
            r_lock_retries   <= '0;
        end else if (i_en) begin
            r_ready_valid    <= n_ready_valid;
            r_ready_desc     <= n_ready_desc;
            r_busy_valid     <= n_busy_valid;
            r_busy_desc      <= n_busy_desc;
            r_retired_valid  <= n_retired_valid;
            r_head           <= n_head;
            r_count          <= n_count;
            r_frames_queued  <= n_frames_queued;
            r_frames_dropped <= n_frames_dropped;
            r_frames_locked  <= n_frames_locked;
            r_lock_retries   <= n_lock_retries;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_status   <= n_status;
            r_desc_q   <= n_desc_q;
            r_from_mem <= n_from_mem;
            r_dropped  <= n_dropped;
        end
    end

    // Free deque write port.
    always_ff @(posedge i_clk) begin
        if (i_en && wr_en) begin
            r_deque[wr_addr] <= wr_data;
        end
    end

    // Free deque read port. A command never reads and writes the deque at once.
    always_ff @(posedge i_clk) begin
        if (i_en && rd_en) begin
            r_rd_q <= r_deque[rd_addr];
        end
    end

    // Result word.
    always_comb begin
        o_res.status         = r_status;
        o_res.desc_out       = lfbx_pkg::FIELD_DESC_W'(r_from_mem ? r_rd_q : r_desc_q);
        o_res.dropped        = r_dropped;
        o_res.frames_queued  = r_frames_queued;
        o_res.frames_dropped = r_frames_dropped;
        o_res.frames_locked  = r_frames_locked;
        o_res.lock_retries   = r_lock_retries;
    end

endmodule

@@ design/latest_frame_buffer_exchange_top.sv @@
// ----------------------------------------------------------------------------
// Latest frame buffer exchange, top level
// Passes frame buffer descriptors from a producer to a consumer, keeping only
// the newest queued frame, with a free deque and event counters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Word
//  command   in         i_in_valid / o_in_stall  i_cmd, i_buf_desc, i_repeat_req
//  result    out        o_out_valid / i_out_stall o_status, o_desc_out, o_dropped,
//                                                o_frames_* and o_lock_retries
//
// One command is accepted in every cycle while the output is not stalled; each
// gives exactly one result word. A word first waits in the input register; the
// core executes it from there when the result register is free, which loads the
// result registers and the registered deque read data together.
// Reset is synchronous and active low; it empties all slots, the deque and
// the counters.
// A stall on the output holds the result and backs up into the input stall.
// ----------------------------------------------------------------------------
module latest_frame_buffer_exchange_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_buf_desc,
    input  logic        i_repeat_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_desc_out,
    output logic        o_dropped,
    output logic [31:0] o_frames_queued,
    output logic [31:0] o_frames_dropped,
    output logic [31:0] o_frames_locked,
    output logic [31:0] o_lock_retries
);

    logic              r_in_valid;
    lfbx_pkg::t_item   r_item;
    logic              r_out_valid;
    logic              advance;
    logic              in_take;
    lfbx_pkg::t_result res;

    // The core executes a command when the result register is free to load.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.cmd        <= lfbx_pkg::t_cmd'(i_cmd);
            r_item.buf_desc   <= i_buf_desc;
            r_item.repeat_req <= i_repeat_req;
        end
    end

    // Result valid tracks the core's result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    lfbx_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .o_res   (res)
    );

    // Output ports.
    assign o_out_valid      = r_out_valid;
    assign o_status         = res.status;
    assign o_desc_out       = res.desc_out;
    assign o_dropped        = res.dropped;
    assign o_frames_queued  = res.frames_queued;
    assign o_frames_dropped = res.frames_dropped;
    assign o_frames_locked  = res.frames_locked;
    assign o_lock_retries   = res.lock_retries;

`ifndef ASSERT_OFF
    // A displaced frame is only reported by a successful queue.
    a_drop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (o_status == lfbx_pkg::ST_OK))
        else $error("dropped flag set on a failed command");

    // A nonzero descriptor is only returned by a successful command.
    a_desc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_desc_out != '0)) |-> (o_status == lfbx_pkg::ST_OK))
        else $error("descriptor returned with a failing status");

    // A command held back by the output stall stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> (r_in_valid && $stable(r_item)))
        else $error("stalled command lost from the input register");

    // The counters move only when a new result is loaded.
    a_ctr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(o_frames_queued) && $stable(o_lock_retries)))
        else $error("event counter changed without a command");
`endif

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Latest frame buffer exchange testbench
// Drives queue, dequeue, lock and unlock commands into the exchange. A
// predictor keeps its own copy of the slots, the free deque and the event
// counters, and every result word is checked field by field against it.
// Sender gaps and receiver stalls vary by phase. One long receiver hold-off
// fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1325;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 64;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ports of the block.
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = 2'd0;
    logic [31:0] i_buf_desc = 32'd0;
    logic        i_repeat_req = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_desc_out;
    logic        o_dropped;
    logic [31:0] o_frames_queued;
    logic [31:0] o_frames_dropped;
    logic [31:0] o_frames_locked;
    logic [31:0] o_lock_retries;

    latest_frame_buffer_exchange_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_buf_desc       (i_buf_desc),
        .i_repeat_req     (i_repeat_req),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_desc_out       (o_desc_out),
        .o_dropped        (o_dropped),
        .o_frames_queued  (o_frames_queued),
        .o_frames_dropped (o_frames_dropped),
        .o_frames_locked  (o_frames_locked),
        .o_lock_retries   (o_lock_retries)
    );

    // Command words waiting to be sent, and result words still owed.
    lfbx_pkg::t_item   cmd_words[$];
    lfbx_pkg::t_result owed_results[$];
    lfbx_pkg::t_item   held_word;
    int                sent_count = 0;
    int                total_words = 0;
    int                error_count = 0;

    // Predicted state of the exchange.
    bit              ready_v;
    lfbx_pkg::t_desc ready_d = '0;
    bit              busy_v;
    lfbx_pkg::t_desc busy_d = '0;
    bit              retired_v;
    lfbx_pkg::t_desc free_q[lfbx_pkg::POOL];
    int              fq_head;
    int              fq_count;
    lfbx_pkg::t_ctr  n_queued = '0;
    lfbx_pkg::t_ctr  n_dropped = '0;
    lfbx_pkg::t_ctr  n_locked = '0;
    lfbx_pkg::t_ctr  n_retries = '0;

    // What the run reached, for the summary.
    int seen_cmd[4];
    int seen_no_room;
    int seen_reuse;
    int seen_retire_clear;
    int seen_no_free;
    int seen_busy_lock;

    // Apply one command word to the predicted state and give its result.
    function automatic lfbx_pkg::t_result exchange_predict(lfbx_pkg::t_item w);
        lfbx_pkg::t_result r;
        int                tail;
        r = '0;
        r.status = lfbx_pkg::ST_OK;
        seen_cmd[w.cmd]++;
        case (w.cmd)
            lfbx_pkg::CMD_QUEUE: begin
                if (fq_count + int'(ready_v) + int'(busy_v) >= lfbx_pkg::POOL) begin
                    r.status = lfbx_pkg::ST_NO_ROOM;
                    seen_no_room++;
                end else begin
                    // A ready frame that is displaced goes to the deque front.
                    if (ready_v) begin
                        fq_head = (fq_head + lfbx_pkg::POOL - 1) % lfbx_pkg::POOL;
                        free_q[fq_head] = ready_d;
                        fq_count++;
                        n_dropped++;
                        r.dropped = 1'b1;
                    end
                    ready_d = lfbx_pkg::t_desc'(w.buf_desc);
                    ready_v = 1'b1;
                    n_queued++;
                end
            end
            lfbx_pkg::CMD_DEQUEUE: begin
                if (fq_count == 0) begin
                    r.status = lfbx_pkg::ST_NO_FREE;
                    seen_no_free++;
                end else begin
                    r.desc_out = lfbx_pkg::t_field_desc'(free_q[fq_head]);
                    fq_head = (fq_head + 1) % lfbx_pkg::POOL;
                    fq_count--;
                    if (fq_count == 0) begin
                        if (retired_v) seen_retire_clear++;
                        retired_v = 1'b0;
                    end
                end
            end
            lfbx_pkg::CMD_LOCK: begin
                if (busy_v) begin
                    r.status = lfbx_pkg::ST_LOCKED;
                    seen_busy_lock++;
                end else if (ready_v) begin
                    busy_d = ready_d;
                    busy_v = 1'b1;
                    ready_v = 1'b0;
                    r.desc_out = lfbx_pkg::t_field_desc'(busy_d);
                    n_locked++;
                end else if (w.repeat_req && retired_v && fq_count > 0) begin
                    // Reuse the retired buffer at the deque tail.
                    tail = (fq_head + fq_count + lfbx_pkg::POOL - 1) % lfbx_pkg::POOL;
                    busy_d = free_q[tail];
                    busy_v = 1'b1;
                    fq_count--;
                    retired_v = 1'b0;
                    r.desc_out = lfbx_pkg::t_field_desc'(busy_d);
                    n_locked++;
                    seen_reuse++;
                end else begin
                    r.status = lfbx_pkg::ST_AGAIN;
                    n_retries++;
                end
            end
            default: begin
                if (!busy_v) begin
                    r.status = lfbx_pkg::ST_NOT_LOCKED;
                end else if (fq_count < lfbx_pkg::POOL) begin
                    fq_count++;
                    tail = (fq_head + fq_count + lfbx_pkg::POOL - 1) % lfbx_pkg::POOL;
                    free_q[tail] = busy_d;
                    busy_v = 1'b0;
                    retired_v = 1'b1;
                end
            end
        endcase
        r.frames_queued  = n_queued;
        r.frames_dropped = n_dropped;
        r.frames_locked  = n_locked;
        r.lock_retries   = n_retries;
        return r;
    endfunction

    // Idling phase by number of words accepted so far: 0 none, 1 sender idle,
    // 2 receiver stalling, 3 both lightly. The tail cycles through all four.
    function automatic int idle_phase(int n);
        if (n < 350) return 0;
        if (n < 700) return 1;
        if (n < 1050) return 2;
        if (n < 1200) return 3;
        return (n / 25) % 4;
    endfunction

    function automatic bit sender_idles(int ph);
        if (ph == 1) return $urandom_range(0, 99) < 77;
        if (ph == 3) return $urandom_range(0, 99) < 11;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls(int ph);
        if (ph == 2) return $urandom_range(0, 99) < 77;
        if (ph == 3) return $urandom_range(0, 99) < 11;
        return 1'b0;
    endfunction

    task automatic add_word(lfbx_pkg::t_cmd c, logic [31:0] d, logic r);
        lfbx_pkg::t_item w;
        w.cmd        = c;
        w.buf_desc   = d;
        w.repeat_req = r;
        cmd_words.push_back(w);
    endtask

    // Driver: offers the next word, holds it while stalled.
    always @(posedge i_clk) begin : word_driver
        lfbx_pkg::t_item nxt;
        bit              busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                owed_results.push_back(exchange_predict(held_word));
                sent_count <= sent_count + 1;
                busy = 1'b0;
            end
            if (!busy) begin
                if (cmd_words.size() > 0 && !sender_idles(idle_phase(sent_count))) begin
                    nxt = cmd_words.pop_front();
                    held_word    <= nxt;
                    i_in_valid   <= 1'b1;
                    i_cmd        <= nxt.cmd;
                    i_buf_desc   <= nxt.buf_desc;
                    i_repeat_req <= nxt.repeat_req;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once while the sender keeps going.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            error_count++;
        end
    endfunction

    // Monitor: checks each accepted result word against the oldest owed one.
    always @(posedge i_clk) begin : result_monitor
        lfbx_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result word with no command outstanding");
                    error_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("desc_out", want.desc_out, o_desc_out);
                    check_field("dropped", 32'(want.dropped), 32'(o_dropped));
                    check_field("frames_queued", want.frames_queued, o_frames_queued);
                    check_field("frames_dropped", want.frames_dropped, o_frames_dropped);
                    check_field("frames_locked", want.frames_locked, o_frames_locked);
                    check_field("lock_retries", want.lock_retries, o_lock_retries);
                end
            end
            i_out_stall <= (hold_left != 0) || receiver_stalls(idle_phase(sent_count));
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int             bias;
        int             pick;
        int             qw;
        int             dw;
        int             lw;
        logic [31:0]    d;
        lfbx_pkg::t_cmd c;

        // Empty pool: every command has nothing to work on.
        add_word(lfbx_pkg::CMD_DEQUEUE, 32'h1234_5678, 1'b1);
        add_word(lfbx_pkg::CMD_UNLOCK, 32'hFFFF_FFFF, 1'b1);
        add_word(lfbx_pkg::CMD_LOCK, 32'h0000_0000, 1'b0);
        add_word(lfbx_pkg::CMD_LOCK, 32'hFFFF_FFFF, 1'b1);
        // Queue extremes, the second one displaces the first.
        add_word(lfbx_pkg::CMD_QUEUE, 32'h0000_0000, 1'b1);
        add_word(lfbx_pkg::CMD_QUEUE, 32'hFFFF_FFFF, 1'b0);
        add_word(lfbx_pkg::CMD_LOCK, 32'h0000_0000, 1'b0);
        add_word(lfbx_pkg::CMD_LOCK, 32'hFFFF_FFFF, 1'b1);
        add_word(lfbx_pkg::CMD_UNLOCK, 32'h0000_0000, 1'b0);
        // Retired buffer: refused without repeat, taken again with it.
        add_word(lfbx_pkg::CMD_LOCK, 32'hDEAD_BEEF, 1'b0);
        add_word(lfbx_pkg::CMD_LOCK, 32'h0000_0000, 1'b1);
        add_word(lfbx_pkg::CMD_UNLOCK, 32'hFFFF_FFFF, 1'b1);
        // Draining the deque pops the retired entry last and clears the mark.
        add_word(lfbx_pkg::CMD_DEQUEUE, 32'h0000_0000, 1'b0);
        add_word(lfbx_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF, 1'b1);
        add_word(lfbx_pkg::CMD_LOCK, 32'h0000_0000, 1'b1);
        // Fill the pool until queue is refused.
        for (int k = 0; k < lfbx_pkg::POOL + 1; k++) begin
            add_word(lfbx_pkg::CMD_QUEUE,
                     (k % 2 == 0) ? 32'hA5A5_A5A5 ^ k : 32'h5A5A_5A5A ^ k, k[0]);
        end
        add_word(lfbx_pkg::CMD_LOCK, 32'hFFFF_FFFF, 1'b1);

        // Random part in bursts that favor the producer, the consumer or neither.
        qw = 35; dw = 20; lw = 25;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 40 == 0) begin
                bias = $urandom_range(0, 2);
                case (bias)
                    0: begin qw = 65; dw = 10; lw = 15; end
                    1: begin qw = 15; dw = 35; lw = 25; end
                    default: begin qw = 35; dw = 20; lw = 25; end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < qw) c = lfbx_pkg::CMD_QUEUE;
            else if (pick < qw + dw) c = lfbx_pkg::CMD_DEQUEUE;
            else if (pick < qw + dw + lw) c = lfbx_pkg::CMD_LOCK;
            else c = lfbx_pkg::CMD_UNLOCK;
            case ($urandom_range(0, 9))
                0: d = 32'h0000_0000;
                1: d = 32'hFFFF_FFFF;
                2: d = $urandom_range(0, 15);
                default: d = $urandom;
            endcase
            add_word(c, d, 1'($urandom_range(0, 1)));
        end
        total_words = cmd_words.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is sent and answered, then let the pipe settle.
        while (sent_count < total_words || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            $error("%0d result words never arrived", owed_results.size());
            error_count++;
        end

        $display("Sent %0d commands: %0d queue, %0d dequeue, %0d lock, %0d unlock.",
                 sent_count, seen_cmd[lfbx_pkg::CMD_QUEUE], seen_cmd[lfbx_pkg::CMD_DEQUEUE],
                 seen_cmd[lfbx_pkg::CMD_LOCK], seen_cmd[lfbx_pkg::CMD_UNLOCK]);
        $display("Drops %0d, pool full %0d, deque empty %0d, busy lock %0d,",
                 n_dropped, seen_no_room, seen_no_free, seen_busy_lock);
        $display("reuse %0d, retire cleared %0d.", seen_reuse, seen_retire_clear);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
